// ===== design/graph_bridge_finder_assert.svh =====
// Assertion macros for the checker file of the bridge finder.
`ifndef GRAPH_BRIDGE_FINDER_ASSERT_SVH
`define GRAPH_BRIDGE_FINDER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GBF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GBF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/gbf_pkg.sv =====
package gbf_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int MAX_EDGES    = 4096;
    localparam int VW           = $clog2(MAX_VERTICES);
    localparam int EW           = $clog2(MAX_EDGES);
    localparam int HW           = EW + 1;

    // Input selector codes carried on tuser.
    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_RUN   = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;

    // Controller state codes.
    localparam logic [3:0] ST_INIT  = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_LD1   = 4'd2;
    localparam logic [3:0] ST_LD2   = 4'd3;
    localparam logic [3:0] ST_QRY   = 4'd4;
    localparam logic [3:0] ST_CLR   = 4'd5;
    localparam logic [3:0] ST_ROOT  = 4'd6;
    localparam logic [3:0] ST_ROOTW = 4'd7;
    localparam logic [3:0] ST_ENTW  = 4'd8;
    localparam logic [3:0] ST_STEP  = 4'd9;
    localparam logic [3:0] ST_STEPW = 4'd10;
    localparam logic [3:0] ST_STEPV = 4'd11;
    localparam logic [3:0] ST_POPW  = 4'd12;
    localparam logic [3:0] ST_DONE  = 4'd13;

    // Half-edge pointer: the top bit marks the end of a list.
    typedef logic [HW:0] t_half;
    localparam t_half HALF_NIL = {1'b1, {HW{1'b0}}};

    // Tree edge a frame was entered by: the top bit marks a root.
    typedef logic [EW:0] t_via;
    localparam t_via VIA_NONE = {1'b1, {EW{1'b0}}};

    // One frame of the depth-first walk.
    typedef struct packed {
        logic [VW-1:0] vert;
        t_via          via;
        t_half         cursor;
        logic [VW-1:0] entry;
        logic [VW-1:0] low;
    } t_frame;

endpackage

// ===== design/graph_bridge_finder.sv =====
// Channel   Direction  Payload (lowest bits first)
// s_axis    in         tuser: func; tdata: end_a, end_b, edge_index
// m_axis    out        tdata: bridge_count, is_bridge, query_end_a, query_end_b, edge_overflow
// cfg       in         vertex_count, 11 bits
//
// A load passes through ST_LD1 and ST_LD2, a query through ST_QRY and ST_DONE; a dropped
// load leaves the block idle. Each memory has one write port. A run clears the bridge
// flags and visited marks, then walks the graph depth first from each unvisited root.
// After reset a pass empties the list heads; no item is accepted meanwhile.
// A result that waits in the output register holds the block in its final state.
module graph_bridge_finder import gbf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // end_a[9:0], end_b[19:10], edge_index[31:20]
    input  logic [1:0]  s_axis_tuser,   // func[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // bridge_count, is_bridge, query_end_a,
                                        // query_end_b, edge_overflow (lowest first)
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data
);

    // Memories.
    logic [2*VW-1:0] edge_mem [MAX_EDGES];
    logic            bflag_mem [MAX_EDGES];
    t_half           head_mem [MAX_VERTICES];
    t_half           next_mem [2*MAX_EDGES];
    logic [VW:0]     vert_mem [MAX_VERTICES];
    t_frame          stack_mem [MAX_VERTICES];

    logic [2*VW-1:0] edge_q;
    logic            bflag_q;
    t_half           head_q;
    t_half           next_q;
    logic [VW:0]     vert_q;
    t_frame          stack_q;

    // Registers.
    logic [3:0]    r_state, n_state;
    logic [10:0]   r_vcount;
    logic [EW:0]   r_nedge, n_nedge;
    logic          r_ovf, n_ovf;
    logic [EW:0]   r_clr, n_clr;
    logic [VW-1:0] r_a, n_a, r_b, n_b;
    logic [VW:0]   r_root, n_root;
    logic [VW-1:0] r_vcnt, n_vcnt;
    logic [VW-1:0] r_found, n_found;
    logic [VW:0]   r_sp, n_sp;
    t_frame        r_top, n_top;
    logic [VW-1:0] r_to, n_to;
    logic [EW-1:0] r_e, n_e;
    logic [VW-1:0] r_ch_low, n_ch_low;
    t_via          r_ch_via, n_ch_via;
    logic [31:0]   r_res, n_res;
    logic          r_ovalid;
    logic [31:0]   r_odata;

    logic [10:0]   cnt;
    logic          in_fire;
    logic [VW-1:0] in_a, in_b;
    logic [EW-1:0] in_idx;
    logic          out_free;

    // Memory port controls.
    logic            edge_we, bflag_we, head_we, next_we, vert_we, stack_we;
    logic [EW-1:0]   edge_waddr, bflag_waddr, edge_raddr, bflag_raddr;
    logic [2*VW-1:0] edge_wdata;
    logic            bflag_wdata;
    logic [VW-1:0]   head_waddr, head_raddr, vert_waddr, vert_raddr;
    logic [VW-1:0]   stack_waddr, stack_raddr;
    t_half           head_wdata, next_wdata;
    logic [HW-1:0]   next_waddr, next_raddr;
    logic [VW:0]     vert_wdata;

    logic [EW-1:0]   cur_e;
    logic [VW-1:0]   cur_to;

    assign cnt = (r_vcount > 11'(MAX_VERTICES)) ? 11'(MAX_VERTICES) : r_vcount;
    assign in_a   = s_axis_tdata[VW-1:0];
    assign in_b   = s_axis_tdata[2*VW-1:VW];
    assign in_idx = s_axis_tdata[31:20];
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_ovalid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    assign cur_e  = r_top.cursor[HW-1:1];
    assign cur_to = r_top.cursor[0] ? edge_q[VW-1:0] : edge_q[2*VW-1:VW];

    // Synchronous memories with registered read data.
    always_ff @(posedge i_clk) begin
        if (edge_we) edge_mem[edge_waddr] <= edge_wdata;
        edge_q <= edge_mem[edge_raddr];
    end
    always_ff @(posedge i_clk) begin
        if (bflag_we) bflag_mem[bflag_waddr] <= bflag_wdata;
        bflag_q <= bflag_mem[bflag_raddr];
    end
    always_ff @(posedge i_clk) begin
        if (head_we) head_mem[head_waddr] <= head_wdata;
        head_q <= head_mem[head_raddr];
    end
    always_ff @(posedge i_clk) begin
        if (next_we) next_mem[next_waddr] <= next_wdata;
        next_q <= next_mem[next_raddr];
    end
    always_ff @(posedge i_clk) begin
        if (vert_we) vert_mem[vert_waddr] <= vert_wdata;
        vert_q <= vert_mem[vert_raddr];
    end
    always_ff @(posedge i_clk) begin
        if (stack_we) stack_mem[stack_waddr] <= r_top;
        stack_q <= stack_mem[stack_raddr];
    end

    // Controller: loads, queries and the depth-first walk.
    always_comb begin
        n_state = r_state;  n_nedge = r_nedge;  n_ovf = r_ovf;  n_clr = r_clr;
        n_a = r_a;  n_b = r_b;  n_root = r_root;  n_vcnt = r_vcnt;
        n_found = r_found;  n_sp = r_sp;  n_top = r_top;  n_to = r_to;
        n_e = r_e;  n_ch_low = r_ch_low;  n_ch_via = r_ch_via;  n_res = r_res;
        edge_we = 1'b0;  edge_waddr = r_nedge[EW-1:0];  edge_wdata = {in_b, in_a};
        edge_raddr = in_idx;
        bflag_we = 1'b0;  bflag_waddr = r_nedge[EW-1:0];  bflag_wdata = 1'b0;
        bflag_raddr = in_idx;
        head_we = 1'b0;  head_waddr = r_a;  head_wdata = HALF_NIL;  head_raddr = in_a;
        next_we = 1'b0;  next_waddr = {r_nedge[EW-1:0], 1'b0};  next_wdata = head_q;
        next_raddr = r_top.cursor[HW-1:0];
        vert_we = 1'b0;  vert_waddr = r_to;  vert_wdata = {1'b1, r_vcnt};
        vert_raddr = r_root[VW-1:0];
        stack_we = 1'b0;  stack_waddr = r_sp[VW-1:0] - VW'(1);
        stack_raddr = r_sp[VW-1:0] - VW'(2);
        edge_raddr = (r_state == ST_STEP) ? cur_e : in_idx;
        case (r_state)
            ST_INIT: begin
                // Empty every adjacency list after reset.
                head_we    = 1'b1;
                head_waddr = r_clr[VW-1:0];
                n_clr      = r_clr + 1'b1;
                if (r_clr[VW-1:0] == VW'(MAX_VERTICES - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_fire) begin
                    n_a = in_a;
                    n_b = in_b;
                    case (s_axis_tuser)
                        FUNC_LOAD: begin
                            if (r_nedge[EW]) begin
                                n_ovf = 1'b1;
                            end else begin
                                edge_we  = 1'b1;
                                bflag_we = 1'b1;
                                n_state  = ST_LD1;
                            end
                        end
                        FUNC_RUN: begin
                            n_clr   = '0;
                            n_state = ST_CLR;
                        end
                        FUNC_QUERY: begin
                            n_e     = in_idx;
                            n_state = ST_QRY;
                        end
                        default: ;
                    endcase
                end
            end
            ST_LD1: begin
                // Link the first half edge and fetch the second endpoint's head.
                next_we    = 1'b1;
                head_we    = 1'b1;
                head_waddr = r_a;
                head_wdata = {1'b0, r_nedge[EW-1:0], 1'b0};
                head_raddr = r_b;
                n_state    = ST_LD2;
            end
            ST_LD2: begin
                // A self loop uses the head written in the cycle before, which the read does not yet return.
                next_we    = 1'b1;
                next_waddr = {r_nedge[EW-1:0], 1'b1};
                next_wdata = (r_a == r_b) ? {1'b0, r_nedge[EW-1:0], 1'b0} : head_q;
                head_we    = 1'b1;
                head_waddr = r_b;
                head_wdata = {1'b0, r_nedge[EW-1:0], 1'b1};
                n_nedge    = r_nedge + 1'b1;
                n_state    = ST_IDLE;
            end
            ST_QRY: begin
                if ({1'b0, r_e} < r_nedge)
                    n_res = {r_ovf, edge_q[2*VW-1:VW], edge_q[VW-1:0], bflag_q, 10'd0};
                else
                    n_res = {r_ovf, 31'd0};
                n_state = ST_DONE;
            end
            ST_CLR: begin
                // Clear bridge flags and visited marks, one address a cycle.
                bflag_we    = 1'b1;
                bflag_waddr = r_clr[EW-1:0];
                vert_we     = (r_clr[EW-1:VW] == '0);
                vert_waddr  = r_clr[VW-1:0];
                vert_wdata  = '0;
                n_clr       = r_clr + 1'b1;
                if (r_clr[EW-1:0] == EW'(MAX_EDGES - 1)) begin
                    n_root  = '0;
                    n_vcnt  = '0;
                    n_found = '0;
                    n_sp    = '0;
                    n_state = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (r_root == cnt) begin
                    n_res   = {r_ovf, 21'd0, r_found};
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_ROOTW;
                end
            end
            ST_ROOTW: begin
                head_raddr = r_root[VW-1:0];
                if (vert_q[VW]) begin
                    n_root  = r_root + 1'b1;
                    n_state = ST_ROOT;
                end else begin
                    vert_we    = 1'b1;
                    vert_waddr = r_root[VW-1:0];
                    n_top.vert  = r_root[VW-1:0];
                    n_top.via   = VIA_NONE;
                    n_top.entry = r_vcnt;
                    n_top.low   = r_vcnt;
                    n_vcnt  = r_vcnt + 1'b1;
                    n_sp    = (VW+1)'(1);
                    n_state = ST_ENTW;
                end
            end
            ST_ENTW: begin
                n_top.cursor = head_q;
                n_state      = ST_STEP;
            end
            ST_STEP: begin
                if (r_top.cursor[HW]) begin
                    if (r_sp == (VW+1)'(1)) begin
                        n_sp    = '0;
                        n_root  = r_root + 1'b1;
                        n_state = ST_ROOT;
                    end else begin
                        n_ch_low = r_top.low;
                        n_ch_via = r_top.via;
                        n_sp     = r_sp - 1'b1;
                        n_state  = ST_POPW;
                    end
                end else begin
                    n_state = ST_STEPW;
                end
            end
            ST_STEPW: begin
                vert_raddr   = cur_to;
                n_top.cursor = next_q;
                n_to         = cur_to;
                n_e          = cur_e;
                if ({1'b0, cur_to} >= cnt || {1'b0, cur_e} == r_top.via)
                    n_state = ST_STEP;
                else
                    n_state = ST_STEPV;
            end
            ST_STEPV: begin
                head_raddr = r_to;
                if (vert_q[VW]) begin
                    if (vert_q[VW-1:0] < r_top.low) n_top.low = vert_q[VW-1:0];
                    n_state = ST_STEP;
                end else begin
                    // Push the current frame and enter the neighbor.
                    stack_we    = 1'b1;
                    vert_we     = 1'b1;
                    n_top.vert  = r_to;
                    n_top.via   = {1'b0, r_e};
                    n_top.entry = r_vcnt;
                    n_top.low   = r_vcnt;
                    n_vcnt  = r_vcnt + 1'b1;
                    n_sp    = r_sp + 1'b1;
                    n_state = ST_ENTW;
                end
            end
            ST_POPW: begin
                // Fold the child's low link into the parent and test the tree edge.
                n_top = stack_q;
                if (r_ch_low < stack_q.low) n_top.low = r_ch_low;
                if (r_ch_low > stack_q.entry) begin
                    bflag_we    = 1'b1;
                    bflag_waddr = r_ch_via[EW-1:0];
                    bflag_wdata = 1'b1;
                    n_found     = r_found + 1'b1;
                end
                n_state = ST_STEP;
            end
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_INIT;
            r_vcount <= 11'(MAX_VERTICES);
            r_nedge  <= '0;
            r_ovf    <= 1'b0;
            r_clr    <= '0;
            r_root   <= '0;
            r_vcnt   <= '0;
            r_found  <= '0;
            r_sp     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_nedge <= n_nedge;
            r_ovf   <= n_ovf;
            r_clr   <= n_clr;
            r_root  <= n_root;
            r_vcnt  <= n_vcnt;
            r_found <= n_found;
            r_sp    <= n_sp;
            if (i_cfg_valid) r_vcount <= i_cfg_data;
            if (r_state == ST_DONE && out_free) r_ovalid <= 1'b1;
            else if (m_axis_tready)              r_ovalid <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_a <= n_a;  r_b <= n_b;  r_top <= n_top;  r_to <= n_to;  r_e <= n_e;
        r_ch_low <= n_ch_low;  r_ch_via <= n_ch_via;  r_res <= n_res;
        if (r_state == ST_DONE && out_free) r_odata <= r_res;
    end

endmodule

// ===== design/gbf_checker.sv =====
`include "graph_bridge_finder_assert.svh"

// Port-level checks of the bridge finder.
module gbf_checker import gbf_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // A stalled result holds.
    `GBF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    // The overflow flag never falls once shown.
    `GBF_ASSERT_NEXT(a_ovf_sticky, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[31], m_axis_tdata[31], "overflow flag fell")

    // A nonzero bridge count comes from a run, whose query fields are zero.
    `GBF_ASSERT_NOW(a_run_fields, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata[9:0] != 10'd0), m_axis_tdata[30:10] == 21'd0, "run result carries query fields")

    // Runs and queries leave the input not ready in the cycle after they are accepted.
    `GBF_ASSERT_NEXT(a_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_RUN || s_axis_tuser == FUNC_QUERY), !s_axis_tready, "ready right after run or query")

endmodule

bind graph_bridge_finder gbf_checker u_gbf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== test/graph_bridge_finder_tb.sv =====
`timescale 1ns / 100ps

module graph_bridge_finder_tb;
    import gbf_pkg::*;

    // Local code for the unused selector value; the block ignores it.
    localparam logic [1:0] FUNC_SPARE = 2'd3;
    localparam int NIL = -1;

    typedef struct packed {
        logic [1:0]  func;
        logic [9:0]  end_a;
        logic [9:0]  end_b;
        logic [11:0] edge_index;
    } t_item;

    typedef struct packed {
        logic        overflow;
        logic [9:0]  q_end_b;
        logic [9:0]  q_end_a;
        logic        is_bridge;
        logic [9:0]  bridge_count;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [10:0] i_cfg_data;

    graph_bridge_finder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // Clock with a 12 ns period.
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Shadow copy of the graph memories and the walk state.
    logic [9:0]  edge_lo [MAX_EDGES];
    logic [9:0]  edge_hi [MAX_EDGES];
    int          adj_head [MAX_VERTICES];
    int          adj_next [2*MAX_EDGES];
    bit          seen [MAX_VERTICES];
    int          enter_num [MAX_VERTICES];
    int          low_num [MAX_VERTICES];
    int          stk_vert [MAX_VERTICES];
    int          stk_via [MAX_VERTICES];
    int          stk_cur [MAX_VERTICES];
    bit          is_bridge_edge [MAX_EDGES];
    int          edges_stored;
    bit          dropped_edge;
    logic [10:0] vcount_shadow;

    t_item   pending_items[$];
    t_result expected_results[$];
    int      fail_count;
    int      send_idle_pct;
    int      recv_stall_pct;
    int      gen_edges;

    // Stores an edge and links both half edges at the head of their lists.
    function automatic void store_edge(logic [9:0] a, logic [9:0] b);
        int e;
        if (edges_stored >= MAX_EDGES) begin
            dropped_edge = 1'b1;
            return;
        end
        e = edges_stored;
        edges_stored++;
        edge_lo[e] = a;
        edge_hi[e] = b;
        is_bridge_edge[e] = 1'b0;
        adj_next[2*e] = adj_head[a];
        adj_head[a] = 2*e;
        adj_next[2*e+1] = adj_head[b];
        adj_head[b] = 2*e + 1;
    endfunction

    // Iterative low-link walk over all vertices below the vertex count.
    function automatic int count_bridges();
        int cnt, found, sp, r, v, h, e, to, via, p, ctr;
        cnt = (vcount_shadow > MAX_VERTICES) ? MAX_VERTICES : int'(vcount_shadow);
        found = 0;
        sp = 0;
        ctr = 0;
        for (int i = 0; i < MAX_VERTICES; i++) seen[i] = 1'b0;
        for (int i = 0; i < MAX_EDGES; i++) is_bridge_edge[i] = 1'b0;
        for (r = 0; r < cnt; r++) begin
            if (seen[r]) continue;
            seen[r] = 1'b1;
            enter_num[r] = ctr;
            low_num[r] = ctr;
            ctr++;
            stk_vert[0] = r;
            stk_via[0] = NIL;
            stk_cur[0] = adj_head[r];
            sp = 1;
            while (sp > 0) begin
                v = stk_vert[sp-1];
                h = stk_cur[sp-1];
                if (h != NIL) begin
                    e = h >> 1;
                    to = (h & 1) ? int'(edge_lo[e]) : int'(edge_hi[e]);
                    stk_cur[sp-1] = adj_next[h];
                    if (to >= cnt || e == stk_via[sp-1]) continue;
                    if (seen[to]) begin
                        if (enter_num[to] < low_num[v]) low_num[v] = enter_num[to];
                    end else if (sp < MAX_VERTICES) begin
                        seen[to] = 1'b1;
                        enter_num[to] = ctr;
                        low_num[to] = ctr;
                        ctr++;
                        stk_vert[sp] = to;
                        stk_via[sp] = e;
                        stk_cur[sp] = adj_head[to];
                        sp++;
                    end
                end else begin
                    via = stk_via[sp-1];
                    sp--;
                    if (sp > 0) begin
                        p = stk_vert[sp-1];
                        if (low_num[v] < low_num[p]) low_num[p] = low_num[v];
                        if (low_num[v] > enter_num[p] && via != NIL) begin
                            is_bridge_edge[via] = 1'b1;
                            found++;
                        end
                    end
                end
            end
        end
        return found;
    endfunction

    // Applies one accepted transaction to the shadow state.
    function automatic void predict_item(t_item it);
        t_result res;
        res = '0;
        case (it.func)
            FUNC_LOAD: store_edge(it.end_a, it.end_b);
            FUNC_RUN: begin
                res.bridge_count = 10'(count_bridges());
                res.overflow = dropped_edge;
                expected_results.insert(expected_results.size(), res);
            end
            FUNC_QUERY: begin
                if (it.edge_index < edges_stored) begin
                    res.is_bridge = is_bridge_edge[it.edge_index];
                    res.q_end_a = edge_lo[it.edge_index];
                    res.q_end_b = edge_hi[it.edge_index];
                end
                res.overflow = dropped_edge;
                expected_results.insert(expected_results.size(), res);
            end
            default: ;
        endcase
    endfunction

    // Driver: presents queued items and predicts each accepted transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                predict_item({s_axis_tuser, s_axis_tdata[9:0], s_axis_tdata[19:10],
                              s_axis_tdata[31:20]});
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    t_item it;
                    it = pending_items.pop_front();
                    s_axis_tuser <= it.func;
                    s_axis_tdata <= {it.edge_index, it.end_b, it.end_a};
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                     exp_val, act_val);
            fail_count++;
        end
    endtask

    // Monitor: random back-pressure and field-by-field comparison.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                t_result got, want;
                got = m_axis_tdata;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time,
                             m_axis_tdata);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("bridge_count", want.bridge_count, got.bridge_count);
                    check_field("is_bridge", want.is_bridge, got.is_bridge);
                    check_field("query_end_a", want.q_end_a, got.q_end_a);
                    check_field("query_end_b", want.q_end_b, got.q_end_b);
                    check_field("edge_overflow", want.overflow, got.overflow);
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic add_item(logic [1:0] f, int a, int b, int idx);
        t_item it;
        it.func = f;
        it.end_a = 10'(a);
        it.end_b = 10'(b);
        it.edge_index = 12'(idx);
        pending_items.insert(pending_items.size(), it);
        if (f == FUNC_LOAD) gen_edges++;
    endtask

    // Waits until the block is idle with nothing outstanding.
    task automatic wait_idle();
        while (pending_items.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_vcount(logic [10:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        vcount_shadow = value;
        i_cfg_valid <= 1'b0;
    endtask

    // Random mix of loads, runs, queries and the odd ignored item.
    task automatic add_random(int n, int span);
        int k, a, b;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 62) begin
                if ($urandom_range(9) == 0) begin
                    a = $urandom_range(1023);
                    b = $urandom_range(1023);
                end else begin
                    a = $urandom_range(span - 1);
                    b = ($urandom_range(19) == 0) ? a : $urandom_range(span - 1);
                end
                add_item(FUNC_LOAD, a, b, $urandom_range(4095));
            end else if (k < 67) begin
                add_item(FUNC_RUN, $urandom_range(1023), $urandom_range(1023),
                         $urandom_range(4095));
            end else if (k < 97) begin
                add_item(FUNC_QUERY, $urandom_range(1023), $urandom_range(1023),
                         ($urandom_range(7) == 0) ? $urandom_range(4095)
                                                  : $urandom_range(gen_edges + 3));
            end else begin
                add_item(FUNC_SPARE, $urandom_range(1023), $urandom_range(1023),
                         $urandom_range(4095));
            end
        end
    endtask

    // Main sequence: reset, directed items, then random phases.
    initial begin
        logic [10:0] vc_list [10];
        int span;
        vc_list = '{11'd8, 11'd40, 11'd1, 11'd200, 11'd0, 11'd16, 11'd2047, 11'd600,
                    11'd24, 11'd1024};
        fail_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        gen_edges = 0;
        edges_stored = 0;
        dropped_edge = 1'b0;
        vcount_shadow = 11'd1024;
        for (int i = 0; i < MAX_VERTICES; i++) adj_head[i] = NIL;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = FUNC_LOAD;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: query before any run, extremes, self loop, parallel pair, chain.
        add_item(FUNC_QUERY, 0, 0, 0);
        add_item(FUNC_RUN, 0, 0, 0);
        add_item(FUNC_LOAD, 0, 1, 0);
        add_item(FUNC_LOAD, 1, 2, 4095);
        add_item(FUNC_LOAD, 2, 3, 0);
        add_item(FUNC_LOAD, 3, 3, 0);
        add_item(FUNC_LOAD, 2, 3, 0);
        add_item(FUNC_LOAD, 1023, 1023, 0);
        add_item(FUNC_LOAD, 1023, 0, 0);
        add_item(FUNC_LOAD, 5, 1023, 0);
        add_item(FUNC_SPARE, 1023, 1023, 4095);
        add_item(FUNC_RUN, 1023, 1023, 4095);
        for (int i = 0; i < 8; i++) add_item(FUNC_QUERY, 0, 0, i);
        add_item(FUNC_QUERY, 1023, 1023, 4095);
        add_item(FUNC_QUERY, 0, 0, 8);
        add_item(FUNC_LOAD, 6, 7, 0);
        add_item(FUNC_QUERY, 0, 0, 8);
        wait_idle();
        write_vcount(11'd6);
        add_item(FUNC_RUN, 0, 0, 0);
        for (int i = 0; i < 9; i++) add_item(FUNC_QUERY, 0, 0, i);

        // Random phases, each under its own vertex count and idling mode.
        for (int ph = 0; ph < 20; ph++) begin
            wait_idle();
            write_vcount(vc_list[ph % 10]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            span = (vc_list[ph % 10] == 0 || vc_list[ph % 10] > 1024) ? 1024
                                                                       : vc_list[ph % 10];
            add_random(63, span);
            add_item(FUNC_RUN, 0, 0, 0);
        end

        wait_idle();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Overall time limit.
    initial begin
        #200_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
